FILE: hw/rtl/cnpj_pkg.sv
// shared constants, types and check-digit helper for the tax id validator
`timescale 1ns / 1ps

package cnpj_pkg;

  localparam int NUM_W         = 47;
  localparam int TDATA_IN_W    = 48;
  localparam int TDATA_OUT_W   = 8;
  localparam int DIGITS        = 14;
  localparam int DABBLE_STAGES = 6;
  localparam int STEPS_PER_STG = 8;
  localparam int SUM_W         = 11;
  localparam int RECIP_W       = 12;
  localparam int RECIP_SHIFT   = 15;

  localparam logic [NUM_W-1:0] LOW_BOUND  = 47'd10000000000000;
  localparam logic [NUM_W-1:0] HIGH_BOUND = 47'd99999999999999;

  // floor(s / 11) == (s * 2979) >> 15 for every s below 2^11
  localparam logic [RECIP_W-1:0] MOD11_RECIP = 12'd2979;

  localparam logic [3:0] FIRST_WEIGHTS [12] = '{
    4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2
  };
  localparam logic [3:0] SECOND_WEIGHTS [13] = '{
    4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2
  };

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic             valid;
    logic             in_range;
    logic [NUM_W-1:0] bin;
    bcd_t             bcd;
  } dabble_t;

  // mod-11 check digit: remainder below 2 gives 0, else 11 - remainder
  function automatic logic [3:0] check_from_sum(input logic [SUM_W-1:0] s);
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [SUM_W-1:0]         q;
    logic [SUM_W-1:0]         q11;
    logic [SUM_W-1:0]         rem;
    prod = s * MOD11_RECIP;
    q    = SUM_W'(prod[SUM_W+RECIP_W-1:RECIP_SHIFT]);
    q11  = (q << 3) + (q << 1) + q;
    rem  = s - q11;
    if (rem[3:0] < 4'd2) begin
      return 4'd0;
    end
    return 4'd11 - rem[3:0];
  endfunction

endpackage

FILE: hw/rtl/tax_id_check_digit_validator_unit.sv
// top level: cnpj mod-11 check-digit validator
`timescale 1ns / 1ps

// Takes one 47-bit binary tax number per transaction on the s_ side and returns one
// is_valid flag per transaction on the m_ side, in order. A new number is accepted
// every cycle while the output is not stalled. Each passes through the input register
// (loaded at the accepting edge), six binary-to-bcd stages of up to eight shift-add-3
// steps each, the weighted-sum register and the result register driving m_tvalid. The
// whole pipeline advances together; it stalls only while a result waits at the output.
module tax_id_check_digit_validator_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [cnpj_pkg::TDATA_IN_W-1:0]   s_tdata,   // [46:0] tax_number
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cnpj_pkg::TDATA_OUT_W-1:0]  m_tdata    // [0] is_valid
);

  logic                         en;
  logic                         in_valid;
  logic [cnpj_pkg::NUM_W-1:0]   in_num;
  cnpj_pkg::dabble_t            stage      [cnpj_pkg::DABBLE_STAGES];
  cnpj_pkg::dabble_t            stage_next [cnpj_pkg::DABBLE_STAGES];
  logic                         sum_valid;
  logic                         sum_in_range;
  logic [cnpj_pkg::SUM_W-1:0]   sum1;
  logic [cnpj_pkg::SUM_W-1:0]   sum2;
  logic [3:0]                   dig12;
  logic [3:0]                   dig13;
  logic [cnpj_pkg::SUM_W-1:0]   sum1_next;
  logic [cnpj_pkg::SUM_W-1:0]   sum2_next;
  logic                         is_valid_next;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= s_tvalid;
    end
    if (en) begin
      in_num <= s_tdata[cnpj_pkg::NUM_W-1:0];
    end
  end

  // binary to bcd, double dabble spread over the stages
  always_comb begin
    cnpj_pkg::dabble_t cur;
    for (int s = 0; s < cnpj_pkg::DABBLE_STAGES; s++) begin
      if (s == 0) begin
        cur.valid    = in_valid;
        cur.in_range = (in_num >= cnpj_pkg::LOW_BOUND) && (in_num <= cnpj_pkg::HIGH_BOUND);
        cur.bin      = in_num;
        cur.bcd      = '0;
      end else begin
        cur = stage[s-1];
      end
      for (int j = 0; j < cnpj_pkg::STEPS_PER_STG; j++) begin
        if (s * cnpj_pkg::STEPS_PER_STG + j < cnpj_pkg::NUM_W) begin
          for (int d = 0; d < cnpj_pkg::DIGITS; d++) begin
            if (cur.bcd[d] >= 4'd5) begin
              cur.bcd[d] = cur.bcd[d] + 4'd3;
            end
          end
          {cur.bcd, cur.bin} = {cur.bcd, cur.bin} << 1;
        end
      end
      stage_next[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < cnpj_pkg::DABBLE_STAGES; s++) begin
        stage[s].valid <= 1'b0;
      end
    end else if (en) begin
      stage <= stage_next;
    end
  end

  // weighted sums, digit i counted from the most significant
  always_comb begin
    cnpj_pkg::bcd_t bcd;
    bcd       = stage[cnpj_pkg::DABBLE_STAGES-1].bcd;
    sum1_next = '0;
    sum2_next = '0;
    for (int i = 0; i < 12; i++) begin
      sum1_next = sum1_next + cnpj_pkg::SUM_W'(bcd[cnpj_pkg::DIGITS-1-i] *
                                               cnpj_pkg::FIRST_WEIGHTS[i]);
    end
    for (int i = 0; i < 13; i++) begin
      sum2_next = sum2_next + cnpj_pkg::SUM_W'(bcd[cnpj_pkg::DIGITS-1-i] *
                                               cnpj_pkg::SECOND_WEIGHTS[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (en) begin
      sum_valid <= stage[cnpj_pkg::DABBLE_STAGES-1].valid;
    end
    if (en) begin
      sum_in_range <= stage[cnpj_pkg::DABBLE_STAGES-1].in_range;
      sum1         <= sum1_next;
      sum2         <= sum2_next;
      dig12        <= stage[cnpj_pkg::DABBLE_STAGES-1].bcd[1];
      dig13        <= stage[cnpj_pkg::DABBLE_STAGES-1].bcd[0];
    end
  end

  assign is_valid_next = sum_in_range &&
                         (dig12 == cnpj_pkg::check_from_sum(sum1)) &&
                         (dig13 == cnpj_pkg::check_from_sum(sum2));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sum_valid;
    end
    if (en) begin
      m_tdata <= {{(cnpj_pkg::TDATA_OUT_W-1){1'b0}}, is_valid_next};
    end
  end

endmodule

FILE: hw/rtl/cnpj_checker.sv
// port-level checks for the tax id validator, bound to the top level
`timescale 1ns / 1ps

module cnpj_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [cnpj_pkg::TDATA_OUT_W-1:0]  m_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // pipeline only stalls on a blocked output
  assert property (@(posedge clk) disable iff (rst)
    (m_tready || !m_tvalid) |-> s_tready)
    else $error("input blocked while output free");

  // pad bits of the result stay zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[cnpj_pkg::TDATA_OUT_W-1:1] == '0))
    else $error("result pad bits set");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result right after reset");

endmodule

bind tax_id_check_digit_validator_unit cnpj_checker u_cnpj_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: dv/tb_top.sv
// self-checking testbench for the cnpj check-digit validator
`timescale 1ns / 1ps

module tb_top;

  localparam longint unsigned MIN_CNPJ    = 64'd10000000000000;
  localparam longint unsigned MAX_CNPJ    = 64'd99999999999999;
  localparam int              PHASE_ITEMS = 295;
  localparam int              HOLD_CYCLES = 120;
  localparam int              DRAIN_WAIT  = 20;

  class cnpj_flag_board;
    bit expected_flags[$];
    int fail_count;

    // mod-11 check digit over the low n decimal digits, weights 2..9 from the right
    static function int unsigned check_digit(input longint unsigned digits, input int n);
      longint unsigned v;
      int unsigned     sum;
      int unsigned     r;
      v   = digits;
      sum = 0;
      for (int j = 0; j < n; j++) begin
        sum += int'(v % 10) * (2 + j % 8);
        v    = v / 10;
      end
      r = sum % 11;
      return (r < 2) ? 0 : 11 - r;
    endfunction

    static function bit cnpj_is_valid(input logic [cnpj_pkg::NUM_W-1:0] num);
      longint unsigned v;
      int unsigned     c1;
      int unsigned     c2;
      v = longint'(num);
      if (v < MIN_CNPJ || v > MAX_CNPJ) begin
        return 1'b0;
      end
      c1 = check_digit(v / 100, 12);
      c2 = check_digit(v / 10, 13);
      return (v % 100) == longint'(c1 * 10 + c2);
    endfunction

    function void note_number(input logic [cnpj_pkg::NUM_W-1:0] num);
      expected_flags.push_back(cnpj_is_valid(num));
    endfunction

    function void check_flag(input bit got);
      bit want;
      if (expected_flags.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result transaction: is_valid=%0b", got);
        end
        return;
      end
      want = expected_flags.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("is_valid mismatch: expected %0b, actual %0b", want, got);
        end
      end
    endfunction
  endclass

  logic                             clk      = 1'b0;
  logic                             rst      = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [cnpj_pkg::TDATA_IN_W-1:0]  s_tdata  = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [cnpj_pkg::TDATA_OUT_W-1:0] m_tdata;

  cnpj_flag_board board = new();
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int inputs_taken = 0;
  int hold_from    = -1;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  tax_id_check_digit_validator_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned rand64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  function automatic longint unsigned valid_from_prefix(input longint unsigned prefix);
    int unsigned c1;
    int unsigned c2;
    c1 = cnpj_flag_board::check_digit(prefix, 12);
    c2 = cnpj_flag_board::check_digit(prefix * 10 + c1, 13);
    return prefix * 100 + c1 * 10 + c2;
  endfunction

  function automatic longint unsigned random_valid();
    return valid_from_prefix(64'd100000000000 + rand64() % 64'd900000000000);
  endfunction

  function automatic longint unsigned random_number();
    longint unsigned v;
    longint unsigned p10;
    int              pick;
    v    = random_valid();
    pick = $urandom_range(99);
    if (pick < 50) begin
      return v;
    end else if (pick < 60) begin
      return (v / 100) * 100 + $urandom_range(99);
    end else if (pick < 70) begin
      p10 = 1;
      repeat ($urandom_range(13)) p10 *= 10;
      return ($urandom_range(1)) ? v + p10 : v - p10;
    end else if (pick < 85) begin
      return MIN_CNPJ + rand64() % (MAX_CNPJ - MIN_CNPJ + 1);
    end
    return rand64() & ((64'd1 << cnpj_pkg::NUM_W) - 1);
  endfunction

  task automatic send_number(input longint unsigned num);
    logic [cnpj_pkg::NUM_W-1:0] n;
    n = num[cnpj_pkg::NUM_W-1:0];
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(cnpj_pkg::TDATA_IN_W-cnpj_pkg::NUM_W){1'b0}}, n};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_number(n);
    inputs_taken++;
    @(negedge clk);
  endtask

  // receiver side, with one long hold-off counted here
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && hold_from >= 0 && inputs_taken >= hold_from) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_flag(m_tdata[0]);
    end
  end

  initial begin
    longint unsigned v;
    longint unsigned zero_c1;
    longint unsigned zero_c2;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: range edges, bit patterns, known good number and near misses
    send_number(64'd0);
    send_number(64'd1);
    send_number(MIN_CNPJ - 1);
    send_number(MIN_CNPJ);
    send_number(MAX_CNPJ);
    send_number(MAX_CNPJ + 1);
    send_number((64'd1 << cnpj_pkg::NUM_W) - 1);
    send_number(64'h2AAA_AAAA_AAAA);
    send_number(64'h5555_5555_5555);
    send_number(64'd11222333000181);
    send_number(64'd11222333000182);
    send_number(64'd11222333000191);
    send_number(64'd11222333000081);
    send_number(valid_from_prefix(64'd100000000000));
    send_number(valid_from_prefix(64'd999999999999));
    send_number(64'd11111111111111);
    // remainder below 2 forcing a zero check digit, in either position
    zero_c1 = 0;
    zero_c2 = 0;
    while (zero_c1 == 0 || zero_c2 == 0) begin
      v = random_valid();
      if ((v / 10) % 10 == 0 && zero_c1 == 0) zero_c1 = v;
      if (v % 10 == 0 && zero_c2 == 0) zero_c2 = v;
    end
    send_number(zero_c1);
    send_number(zero_c1 + 10);
    send_number(zero_c2);
    send_number(zero_c2 + 1);

    send_gap_pct = 34;
    recv_gap_pct = 83;
    repeat (PHASE_ITEMS) send_number(random_number());
    send_gap_pct = 83;
    recv_gap_pct = 34;
    repeat (PHASE_ITEMS) send_number(random_number());
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_from    = inputs_taken + 20;
    repeat (PHASE_ITEMS) send_number(random_number());
    s_tvalid <= 1'b0;

    while (board.expected_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.fail_count == 0) begin
      $display("PASS tax_id_check_digit_validator_unit");
    end else begin
      $display("FAIL tax_id_check_digit_validator_unit");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL tax_id_check_digit_validator_unit");
    $finish;
  end

endmodule
